/* src/decision_tree_inference_macros.svh */
// Assertion macros for the checker of the decision tree block.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef DECISION_TREE_INFERENCE_MACROS_SVH
`define DECISION_TREE_INFERENCE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DTI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/dti_pkg.sv */
`default_nettype none

package dti_pkg;

    localparam int NODE_COUNT    = 1024;
    localparam int FEATURE_COUNT = 256;
    localparam int MAX_STEPS     = 1023;

    localparam int MODE_W  = 2;
    localparam int NODE_W  = 10;
    localparam int FEAT_W  = 8;
    localparam int WORD_W  = 64;
    localparam int VALUE_W = 32;
    localparam int STEP_W  = 10;

    localparam int NODE_AW    = $clog2(NODE_COUNT);
    localparam int FEAT_AW    = $clog2(FEATURE_COUNT);
    localparam int STEP_CNT_W = $clog2(MAX_STEPS + 1);

    typedef logic [MODE_W-1:0] mode_t;

    localparam mode_t MODE_NODE    = 2'd0;
    localparam mode_t MODE_FEATURE = 2'd1;
    localparam mode_t MODE_WALK    = 2'd2;

    typedef struct packed {
        mode_t                      mode;
        logic [NODE_W-1:0]          node_index;
        logic [NODE_W-1:0]          left_child;
        logic [NODE_W-1:0]          right_child;
        logic [FEAT_W-1:0]          feature_index;
        logic [WORD_W-1:0]          split_word;
        logic signed [VALUE_W-1:0]  feature_value;
        logic                       ordered;
    } cmd_t;

    typedef struct packed {
        logic [NODE_W-1:0] left_child;
        logic [NODE_W-1:0] right_child;
        logic [FEAT_W-1:0] feature_index;
        logic [WORD_W-1:0] split_word;
    } node_entry_t;

    typedef struct packed {
        logic                      ordered;
        logic signed [VALUE_W-1:0] value;
    } feat_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NODE,
        ST_FEAT,
        ST_RESULT
    } walk_state_t;

    // An ordered feature goes left when value <= threshold. A categorical
    // feature goes left unless its level lies in 1..64 and the matching
    // mask bit is set.
    function automatic logic goes_left(input logic ordered,
                                       input logic [VALUE_W-1:0] value,
                                       input logic [WORD_W-1:0] word);
        logic [15:0] level;
        logic [5:0]  bit_sel;
        logic        result;
        level   = value[31:16];
        bit_sel = 6'(level - 16'd1);
        if (ordered)
        begin
            result = ($signed(value) <= $signed(word[31:0]));
        end
        else if (value[31] || level == 16'd0 || level > 16'd64)
        begin
            result = 1'b1;
        end
        else
        begin
            result = ~word[bit_sel];
        end
        return result;
    endfunction

endpackage

`default_nettype wire

/* src/dti_ifs.sv */
`default_nettype none

interface dti_item_if import dti_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [MODE_W-1:0]         mode;
    logic [NODE_W-1:0]         node_index;
    logic [NODE_W-1:0]         left_child;
    logic [NODE_W-1:0]         right_child;
    logic [FEAT_W-1:0]         feature_index;
    logic [WORD_W-1:0]         split_word;
    logic signed [VALUE_W-1:0] feature_value;
    logic                      ordered;

    modport source (
        output valid, mode, node_index, left_child, right_child,
               feature_index, split_word, feature_value, ordered,
        input  ready
    );

    modport sink (
        input  valid, mode, node_index, left_child, right_child,
               feature_index, split_word, feature_value, ordered,
        output ready
    );
endinterface

interface dti_result_if import dti_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] leaf_node;
    logic [STEP_W-1:0] steps_taken;
    logic              overrun;

    modport source (
        output valid, leaf_node, steps_taken, overrun,
        input  ready
    );

    modport sink (
        input  valid, leaf_node, steps_taken, overrun,
        output ready
    );
endinterface

`default_nettype wire

/* src/dti_ram.sv */
`default_nettype none

module dti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* src/dti_front.sv */
`default_nettype none

module dti_front import dti_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    dti_item_if.sink  item,
    output cmd_t      cmd,
    output logic      cmd_valid,
    input  wire logic cmd_ready
);

    cmd_t       queue_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       keep;
    logic       push;
    logic       pop;
    cmd_t       incoming;

    assign incoming = '{
        mode:          item.mode,
        node_index:    item.node_index,
        left_child:    item.left_child,
        right_child:   item.right_child,
        feature_index: item.feature_index,
        split_word:    item.split_word,
        feature_value: item.feature_value,
        ordered:       item.ordered
    };

    // Writes beyond the stores and the unused mode are dropped here.
    always_comb
    begin
        unique case (item.mode)
            MODE_NODE:    keep = (32'(item.node_index) < NODE_COUNT);
            MODE_FEATURE: keep = (32'(item.feature_index) < FEATURE_COUNT);
            MODE_WALK:    keep = 1'b1;
            default:      keep = 1'b0;
        endcase
    end

    assign item.ready = (count_reg != 2'd2);
    assign push       = item.valid && item.ready && keep;
    assign cmd_valid  = (count_reg != 2'd0);
    assign cmd        = queue_reg[rd_ptr_reg];
    assign pop        = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

`default_nettype wire

/* src/dti_back.sv */
`default_nettype none

module dti_back import dti_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cmd_t    cmd,
    input  wire logic    cmd_valid,
    output logic         cmd_ready,
    dti_result_if.source result
);

    walk_state_t           state_reg, state_next;
    logic [NODE_W-1:0]     node_reg, node_next;
    logic [STEP_CNT_W-1:0] steps_reg, steps_next;
    node_entry_t           entry_reg, entry_next;
    logic                  over_reg, over_next;

    logic                  out_valid_reg, out_valid_next;
    logic [NODE_W-1:0]     leaf_reg;
    logic [STEP_W-1:0]     steps_out_reg;
    logic                  overrun_reg;
    logic                  out_load;

    logic                  node_we;
    logic                  feat_we;
    logic [NODE_AW-1:0]    node_raddr;
    node_entry_t           node_wdata;
    node_entry_t           node_rdata;
    feat_entry_t           feat_wdata;
    feat_entry_t           feat_rdata;
    logic                  is_leaf;
    logic                  turn_left;
    logic [NODE_W-1:0]     child;

    assign cmd_ready = (state_reg == ST_IDLE);

    assign node_we    = cmd_valid && cmd_ready && (cmd.mode == MODE_NODE);
    assign feat_we    = cmd_valid && cmd_ready && (cmd.mode == MODE_FEATURE);
    assign node_wdata = '{
        left_child:    cmd.left_child,
        right_child:   cmd.right_child,
        feature_index: cmd.feature_index,
        split_word:    cmd.split_word
    };
    assign feat_wdata = '{ordered: cmd.ordered, value: cmd.feature_value};

    dti_ram #(
        .WIDTH ($bits(node_entry_t)),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (cmd.node_index[NODE_AW-1:0]),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    dti_ram #(
        .WIDTH ($bits(feat_entry_t)),
        .DEPTH (FEATURE_COUNT)
    ) u_feat_ram (
        .clk   (clk),
        .we    (feat_we),
        .waddr (cmd.feature_index[FEAT_AW-1:0]),
        .wdata (feat_wdata),
        .raddr (node_rdata.feature_index[FEAT_AW-1:0]),
        .rdata (feat_rdata)
    );

    // A child beyond the node store reads as a leaf.
    assign is_leaf = (32'(node_reg) >= NODE_COUNT) ||
                     (node_rdata.left_child == '0 && node_rdata.right_child == '0);

    // A split feature beyond the feature store reads as a categorical zero.
    assign turn_left = (32'(entry_reg.feature_index) >= FEATURE_COUNT) ||
                       goes_left(feat_rdata.ordered, feat_rdata.value,
                                 entry_reg.split_word);
    assign child     = turn_left ? entry_reg.left_child : entry_reg.right_child;

    assign out_load = (state_reg == ST_RESULT) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next = state_reg;
        node_next  = node_reg;
        steps_next = steps_reg;
        entry_next = entry_reg;
        over_next  = over_reg;
        node_raddr = node_reg[NODE_AW-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                node_raddr = '0;
                if (cmd_valid && cmd.mode == MODE_WALK)
                begin
                    node_next  = '0;
                    steps_next = '0;
                    over_next  = 1'b0;
                    state_next = ST_NODE;
                end
            end
            ST_NODE:
            begin
                entry_next = node_rdata;
                if (is_leaf)
                begin
                    over_next  = 1'b0;
                    state_next = ST_RESULT;
                end
                else if (32'(steps_reg) >= MAX_STEPS)
                begin
                    over_next  = 1'b1;
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_FEAT;
                end
            end
            ST_FEAT:
            begin
                node_raddr = child[NODE_AW-1:0];
                node_next  = child;
                steps_next = steps_reg + 1'b1;
                state_next = ST_NODE;
            end
            ST_RESULT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg  <= node_next;
        steps_reg <= steps_next;
        entry_reg <= entry_next;
        over_reg  <= over_next;
        if (out_load)
        begin
            leaf_reg      <= node_reg;
            steps_out_reg <= STEP_W'(steps_reg);
            overrun_reg   <= over_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.leaf_node   = leaf_reg;
    assign result.steps_taken = steps_out_reg;
    assign result.overrun     = overrun_reg;

endmodule

`default_nettype wire

/* src/decision_tree_inference.sv */
// Node and feature writes are taken by the back end after the queue while it is idle.
// In a walk, each edge is one node memory read followed by one feature memory read.
// A two-entry queue lets items arrive while a walk runs; only one walk is in flight at a time.
// Reset (rst_n low, asynchronous) empties the queue and the result register;
// the node and feature memories keep their contents and are not cleared.
`default_nettype none

module decision_tree_inference import dti_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    dti_item_if.sink     item,
    dti_result_if.source result
);

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_ready;

    dti_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready)
    );

    dti_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .result    (result)
    );

endmodule

`default_nettype wire

/* src/dti_checker.sv */
`default_nettype none

`include "decision_tree_inference_macros.svh"

module dti_checker import dti_pkg::*; (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              result_valid,
    input wire logic              result_ready,
    input wire logic [NODE_W-1:0] leaf_node,
    input wire logic [STEP_W-1:0] steps_taken,
    input wire logic              overrun
);

    `DTI_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid, "result dropped while stalled")
    `DTI_ASSERT_NEXT(a_result_stable, result_valid && !result_ready, $stable(leaf_node) && $stable(steps_taken) && $stable(overrun), "result changed while stalled")
    `DTI_ASSERT_SAME(a_overrun_steps, result_valid && overrun, steps_taken == STEP_W'(MAX_STEPS), "overrun with wrong step count")
    `DTI_ASSERT_SAME(a_root_leaf, result_valid && steps_taken == '0 && !overrun, leaf_node == '0, "walk without edges ended away from the root")

endmodule

bind decision_tree_inference dti_checker u_dti_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .leaf_node    (result.leaf_node),
    .steps_taken  (result.steps_taken),
    .overrun      (result.overrun)
);

`default_nettype wire
